### rtl/ir_stop_and_wait_link_defines.svh
// ----------------------------------------------------------------------------
// ir_stop_and_wait_link_defines
// assertion macros shared by the link modules
// ----------------------------------------------------------------------------
`ifndef IR_STOP_AND_WAIT_LINK_DEFINES_SVH
`define IR_STOP_AND_WAIT_LINK_DEFINES_SVH

// condition holds at every edge out of reset
`define SAWL_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ir_stop_and_wait_link: assertion failed");

// consequence holds in the same cycle
`define SAWL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ir_stop_and_wait_link: assertion failed");

// consequence holds in the next cycle
`define SAWL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ir_stop_and_wait_link: assertion failed");

`endif

### rtl/ir_sawl_pkg.sv
// ----------------------------------------------------------------------------
// ir_sawl_pkg
// types, constants and helpers of the stop-and-wait link
// ----------------------------------------------------------------------------
package ir_sawl_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned TICK_W = 8;
  localparam int unsigned REM_CNT_W = $clog2(TICK_W + 1);
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned KIND_W = 2;

  localparam logic [7:0] TYPE_MARK     = 8'hB0;
  localparam logic [7:0] TYPE_HI_NIBBLE = 8'hF0;
  localparam logic [7:0] ACK_BYTE      = 8'hAC;
  localparam logic [7:0] DATA_MARK     = 8'h40;
  localparam logic [7:0] DATA_TOP_BITS = 8'hC0;
  localparam logic [2:0] VOTE_HALF     = 3'd3;

  localparam logic [3:0] VOTE_TYPE_RST     = 4'd2;
  localparam logic [7:0] RESEND_PERIOD_RST = 8'd28;
  localparam logic [7:0] DATA_OFFSET_RST   = 8'd14;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_VOTE_TYPE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RESEND_PERIOD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_OFFSET   = 2'd2;

  typedef enum logic [3:0] {
    OP_TICK  = 4'b0001,
    OP_SEND  = 4'b0010,
    OP_CLEAR = 4'b0100,
    OP_NONE  = 4'b1000
  } op_t;

  typedef enum logic [3:0] {
    RX_NONE = 4'b0001,
    RX_ACK  = 4'b0010,
    RX_TYPE = 4'b0100,
    RX_DATA = 4'b1000
  } rx_t;

  typedef struct packed {
    op_t        op;
    rx_t        rx;
    logic [3:0] nib;
    logic [5:0] bits;
  } cmd_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       pending;
    logic       in_ready;
    logic [3:0] in_type;
    logic [5:0] in_data;
  } result_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [TICK_W-1:0] value;
  } rem_t;

  function automatic logic [2:0] ones6(input logic [5:0] v);
    logic [2:0] c;
    c = '0;
    for (int i = 0; i < 6; i++) begin
      c = c + {2'b00, v[i]};
    end
    return c;
  endfunction

endpackage

### rtl/ir_sawl_front.sv
// ----------------------------------------------------------------------------
// ir_sawl_front
// accepts input transactions, classifies them and queues the commands
// ----------------------------------------------------------------------------
`include "ir_stop_and_wait_link_defines.svh"

module ir_sawl_front #(
  parameter int unsigned DEPTH = ir_sawl_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // rx_valid, rx_byte, send_type, send_data
  input  logic [ir_sawl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // kind
  input  logic [ir_sawl_pkg::KIND_W-1:0]       s_axis_tuser,
  input  logic                                 hold,
  output logic                                 q_valid,
  input  logic                                 q_ready,
  output ir_sawl_pkg::cmd_t                    q_cmd
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ir_sawl_pkg::cmd_t queue [DEPTH];
  ir_sawl_pkg::cmd_t cmd;
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              push;
  logic              pop;
  logic              rx_valid;
  logic [7:0]        rx_byte;
  logic [3:0]        send_type;
  logic [5:0]        send_data;

  assign rx_valid  = s_axis_tdata[0];
  assign rx_byte   = s_axis_tdata[8:1];
  assign send_type = s_axis_tdata[12:9];
  assign send_data = s_axis_tdata[18:13];

  always_comb begin
    cmd.op   = ir_sawl_pkg::OP_NONE;
    cmd.rx   = ir_sawl_pkg::RX_NONE;
    cmd.nib  = rx_byte[3:0];
    cmd.bits = rx_byte[5:0];
    case (s_axis_tuser)
      ir_sawl_pkg::KIND_TICK: begin
        cmd.op = ir_sawl_pkg::OP_TICK;
        if (!rx_valid) begin
          cmd.rx = ir_sawl_pkg::RX_NONE;
        end else if (rx_byte == ir_sawl_pkg::ACK_BYTE) begin
          cmd.rx = ir_sawl_pkg::RX_ACK;
        end else if ((rx_byte & ir_sawl_pkg::TYPE_HI_NIBBLE) == ir_sawl_pkg::TYPE_MARK) begin
          cmd.rx = ir_sawl_pkg::RX_TYPE;
        end else if ((rx_byte & ir_sawl_pkg::DATA_TOP_BITS) == ir_sawl_pkg::DATA_MARK) begin
          cmd.rx = ir_sawl_pkg::RX_DATA;
        end
      end
      ir_sawl_pkg::KIND_SEND: begin
        cmd.op   = ir_sawl_pkg::OP_SEND;
        cmd.nib  = send_type;
        cmd.bits = send_data;
      end
      ir_sawl_pkg::KIND_CLEAR: begin
        cmd.op = ir_sawl_pkg::OP_CLEAR;
      end
      default: begin
        cmd.op = ir_sawl_pkg::OP_NONE;
      end
    endcase
  end

  assign s_axis_tready = (count < CW'(DEPTH)) && !hold;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign pop           = q_valid && q_ready;
  assign q_cmd         = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SAWL_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH))
  `SAWL_ASSERT_NEXT(a_count_up, push && !pop, count == CW'($past(count) + 1'b1))
  `SAWL_ASSERT_NEXT(a_count_down, pop && !push, count == CW'($past(count) - 1'b1))

endmodule

### rtl/ir_sawl_rem.sv
// ----------------------------------------------------------------------------
// ir_sawl_rem
// bit-serial remainder of the tick count by the resend period
// ----------------------------------------------------------------------------
module ir_sawl_rem (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ir_sawl_pkg::TICK_W-1:0]     dividend,
  input  logic [ir_sawl_pkg::TICK_W-1:0]     period,
  output ir_sawl_pkg::rem_t                  status
);

  localparam int unsigned TW = ir_sawl_pkg::TICK_W;
  localparam int unsigned CW = ir_sawl_pkg::REM_CNT_W;

  logic [CW-1:0] cnt;
  logic [TW-1:0] rem;
  logic [TW-1:0] dvd;
  logic [TW:0]   div;
  logic [TW:0]   trial;
  logic          done;

  // zero period counts as a full wrap of the tick counter
  assign trial = {rem, dvd[TW-1]};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      div <= (period == '0) ? (TW + 1)'(1 << TW) : {1'b0, period};
    end else if (cnt != '0) begin
      dvd <= {dvd[TW-2:0], 1'b0};
      if (trial >= div) begin
        rem <= TW'(trial - div);
      end else begin
        rem <= TW'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1)) && !start;
      if (start) begin
        cnt <= CW'(TW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign status.busy  = (cnt != '0);
  assign status.done  = done;
  assign status.value = rem;

endmodule

### rtl/ir_sawl_back.sv
// ----------------------------------------------------------------------------
// ir_sawl_back
// link state, retransmit timing and result output buffer
// ----------------------------------------------------------------------------
`include "ir_stop_and_wait_link_defines.svh"

module ir_sawl_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  output logic                                   q_ready,
  input  ir_sawl_pkg::cmd_t                      q_cmd,
  output logic                                   hold,
  input  logic                                   cfg_we,
  input  logic [ir_sawl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ir_sawl_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tx_valid, tx_byte, pending, in_ready, in_type, in_data
  output logic [ir_sawl_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                                   m_axis_tlast
);

  localparam int unsigned TW = ir_sawl_pkg::TICK_W;

  logic [3:0]    vote_type;
  logic [7:0]    resend_period;
  logic [7:0]    data_offset;
  logic          cfg_pend;

  logic [7:0]    out_type;
  logic [7:0]    out_data;
  logic [TW-1:0] tick;
  logic [TW-1:0] phase;
  logic          led;
  logic [3:0]    held_type;
  logic [5:0]    held_data;
  logic          ready;

  logic [7:0]    out_type_next;
  logic [7:0]    out_data_next;
  logic [TW-1:0] tick_next;
  logic [TW-1:0] phase_next;
  logic [TW-1:0] tick_base;
  logic [TW-1:0] phase_base;
  logic          led_next;
  logic [3:0]    held_type_next;
  logic [5:0]    held_data_next;
  logic          ready_next;

  logic [TW:0]   period_ext;
  logic [2:0]    ones;
  logic          ack;
  logic          tx;
  logic [7:0]    tx_byte;

  ir_sawl_pkg::result_t res_first;
  ir_sawl_pkg::result_t res_second;
  ir_sawl_pkg::result_t buf0;
  ir_sawl_pkg::result_t buf1;
  logic [1:0]           ocnt;
  logic                 take;
  logic                 can_load;
  logic                 pop;
  ir_sawl_pkg::rem_t    rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_type     <= ir_sawl_pkg::VOTE_TYPE_RST;
      resend_period <= ir_sawl_pkg::RESEND_PERIOD_RST;
      data_offset   <= ir_sawl_pkg::DATA_OFFSET_RST;
      cfg_pend      <= 1'b0;
    end else begin
      cfg_pend <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          ir_sawl_pkg::REG_VOTE_TYPE:     vote_type     <= cfg_data[3:0];
          ir_sawl_pkg::REG_RESEND_PERIOD: resend_period <= cfg_data;
          ir_sawl_pkg::REG_DATA_OFFSET:   data_offset   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // phase tracks tick modulo period; rebuilt after each config write
  ir_sawl_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_pend),
    .dividend (tick),
    .period   (resend_period),
    .status   (rem)
  );

  assign hold = cfg_we || cfg_pend || rem.busy || rem.done;

  assign period_ext = (resend_period == '0) ? (TW + 1)'(1 << TW) : {1'b0, resend_period};

  always_comb begin
    out_type_next  = out_type;
    out_data_next  = out_data;
    tick_next      = tick;
    phase_next     = phase;
    tick_base      = tick;
    phase_base     = phase;
    led_next       = led;
    held_type_next = held_type;
    held_data_next = held_data;
    ready_next     = ready;
    ones           = ir_sawl_pkg::ones6(q_cmd.bits);
    ack            = 1'b0;
    tx             = 1'b0;
    tx_byte        = '0;
    case (q_cmd.op)
      ir_sawl_pkg::OP_SEND: begin
        out_type_next = ir_sawl_pkg::TYPE_MARK | {4'b0000, q_cmd.nib};
        out_data_next = ir_sawl_pkg::DATA_MARK | {2'b00, q_cmd.bits};
        tick_next     = '0;
        phase_next    = '0;
        led_next      = 1'b1;
      end
      ir_sawl_pkg::OP_CLEAR: begin
        ready_next     = 1'b0;
        held_data_next = '0;
        held_type_next = '0;
      end
      ir_sawl_pkg::OP_TICK: begin
        case (q_cmd.rx)
          ir_sawl_pkg::RX_ACK: begin
            out_type_next = '0;
            out_data_next = '0;
            led_next      = 1'b0;
          end
          ir_sawl_pkg::RX_TYPE: begin
            held_type_next = q_cmd.nib;
          end
          ir_sawl_pkg::RX_DATA: begin
            if (held_type != '0) begin
              if (held_type == vote_type) begin
                held_data_next = {5'b00000, ones > ir_sawl_pkg::VOTE_HALF};
                ack            = (ones != ir_sawl_pkg::VOTE_HALF);
              end else begin
                held_data_next = q_cmd.bits;
                ack            = 1'b1;
              end
              if (ack) begin
                ready_next = 1'b1;
              end
            end
          end
          default: ;
        endcase
        if (out_type_next != '0) begin
          if (phase == '0) begin
            tx         = 1'b1;
            tx_byte    = out_type;
            tick_base  = '0;
            phase_base = '0;
          end else if (tick == data_offset) begin
            tx      = 1'b1;
            tx_byte = out_data;
          end
          tick_next = tick_base + 1'b1;
          // a wrap of the tick count to zero is a multiple of any period
          if (tick_next == '0) begin
            phase_next = '0;
          end else begin
            phase_next = (({1'b0, phase_base} + 1'b1) == period_ext) ? '0 : phase_base + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_first.tx_valid = ack || tx;
    res_first.tx_byte  = ack ? ir_sawl_pkg::ACK_BYTE : tx_byte;
    res_first.last     = !(ack && tx);
    res_first.pending  = led_next;
    res_first.in_ready = ready_next;
    res_first.in_type  = ready_next ? held_type_next : '0;
    res_first.in_data  = ready_next ? held_data_next : '0;
    res_second          = res_first;
    res_second.tx_valid = 1'b1;
    res_second.tx_byte  = tx_byte;
    res_second.last     = 1'b1;
  end

  assign take     = (ocnt != '0) && m_axis_tready;
  assign can_load = (ocnt == 2'd0) || ((ocnt == 2'd1) && m_axis_tready);
  assign q_ready  = can_load && !hold;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= res_first;
      buf1 <= res_second;
    end else if (take && (ocnt == 2'd2)) begin
      buf0 <= buf1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt      <= '0;
      out_type  <= '0;
      out_data  <= '0;
      tick      <= '0;
      phase     <= '0;
      led       <= 1'b0;
      held_type <= '0;
      held_data <= '0;
      ready     <= 1'b0;
    end else begin
      if (pop) begin
        ocnt      <= (ack && tx) ? 2'd2 : 2'd1;
        out_type  <= out_type_next;
        out_data  <= out_data_next;
        tick      <= tick_next;
        phase     <= phase_next;
        led       <= led_next;
        held_type <= held_type_next;
        held_data <= held_data_next;
        ready     <= ready_next;
      end else begin
        if (take) begin
          ocnt <= ocnt - 1'b1;
        end
        if (rem.done) begin
          phase <= rem.value;
        end
      end
    end
  end

  assign m_axis_tvalid = (ocnt != '0);
  assign m_axis_tlast  = buf0.last;
  assign m_axis_tdata  = {3'b000, buf0.in_data, buf0.in_type, buf0.in_ready, buf0.pending,
                          buf0.tx_byte, buf0.tx_valid};

  `SAWL_ASSERT_IMPL(a_pair_first_not_last, ocnt == 2'd2, !buf0.last)
  `SAWL_ASSERT_NEXT(a_send_sets_pending, pop && (q_cmd.op == ir_sawl_pkg::OP_SEND), led)
  `SAWL_ASSERT_IMPL(a_inbound_zero_when_not_ready, (ocnt != '0) && !buf0.in_ready,
                    (buf0.in_type == '0) && (buf0.in_data == '0))

endmodule

### rtl/ir_stop_and_wait_link.sv
// ----------------------------------------------------------------------------
// ir_stop_and_wait_link
// stop-and-wait link over a byte channel with ack, resend and vote decode
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless back-pressure, a full
// queue or a configuration write stalls it. Each input transaction gives one
// result, or two (ack first) when a received data byte is acked on a tick that
// also resends a type or data byte; a short command queue absorbs such a pair.
// After every configuration write the input stalls while an 8-step serial
// remainder unit rebuilds the resend phase from the tick count.
module ir_stop_and_wait_link #(
  parameter int unsigned QUEUE_DEPTH = ir_sawl_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // rx_valid, rx_byte, send_type, send_data
  input  logic [ir_sawl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // kind
  input  logic [ir_sawl_pkg::KIND_W-1:0]        s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tx_valid, tx_byte, pending, in_ready, in_type, in_data
  output logic [ir_sawl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_we,
  input  logic [ir_sawl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ir_sawl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic              q_valid;
  logic              q_ready;
  logic              hold;
  ir_sawl_pkg::cmd_t q_cmd;

  ir_sawl_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .hold          (hold),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_cmd         (q_cmd)
  );

  ir_sawl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_cmd         (q_cmd),
    .hold          (hold),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stop-and-wait link. A short table of directed
// transactions covers reset state, field extremes, the unused kind, tie votes
// and data without a type; then several configuration phases of random
// traffic, with long-period and wrap-around resend phases, are checked against
// a cycle-free model of the link. Both stream sides idle in random bursts and
// the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ir_sawl_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_DIRECTED = 23;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [1:0]           kind;
    logic                 rxv;
    logic [7:0]           rxb;
    logic [3:0]           stype;
    logic [5:0]           sdata;
    logic                 typed;
    ir_sawl_pkg::result_t want;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ir_sawl_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [ir_sawl_pkg::KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ir_sawl_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [ir_sawl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ir_sawl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ir_stop_and_wait_link dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // link model state
  logic [3:0] cfg_vote = ir_sawl_pkg::VOTE_TYPE_RST;
  logic [7:0] cfg_period = ir_sawl_pkg::RESEND_PERIOD_RST;
  logic [7:0] cfg_offset = ir_sawl_pkg::DATA_OFFSET_RST;
  logic [7:0] link_tx_type = '0;
  logic [7:0] link_tx_data = '0;
  logic [7:0] resend_ticks = '0;
  logic link_pending = 1'b0;
  logic [3:0] rx_type_held = '0;
  logic [5:0] rx_data_held = '0;
  logic rx_ready = 1'b0;

  ir_sawl_pkg::result_t step_results [2];
  int step_count;

  stim_t offered [$];
  ir_sawl_pkg::result_t awaited_results [$];
  int mismatches = 0;
  int results_seen = 0;
  bit quiet = 1'b0;

  function automatic ir_sawl_pkg::result_t res(logic txv, logic [7:0] b, logic pend,
                                               logic rdy, logic [3:0] ty, logic [5:0] da);
    ir_sawl_pkg::result_t r;
    r.tx_valid = txv;
    r.tx_byte = b;
    r.last = 1'b1;
    r.pending = pend;
    r.in_ready = rdy;
    r.in_type = ty;
    r.in_data = da;
    return r;
  endfunction

  function automatic stim_t row(logic [1:0] kind, logic rxv, logic [7:0] rxb,
                                logic [3:0] st, logic [5:0] sd, logic typed,
                                ir_sawl_pkg::result_t want);
    stim_t s;
    s.kind = kind;
    s.rxv = rxv;
    s.rxb = rxb;
    s.stype = st;
    s.sdata = sd;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic void emit_byte(logic v, logic [7:0] b);
    step_results[step_count] = '0;
    step_results[step_count].tx_valid = v;
    step_results[step_count].tx_byte = v ? b : 8'h00;
    step_count++;
  endfunction

  function automatic void predict_link_step(stim_t it);
    int ones;
    logic ack;
    int unsigned per;
    step_count = 0;
    case (it.kind)
      ir_sawl_pkg::KIND_SEND: begin
        link_tx_type = ir_sawl_pkg::TYPE_MARK | {4'h0, it.stype};
        link_tx_data = ir_sawl_pkg::DATA_MARK | {2'b00, it.sdata};
        resend_ticks = '0;
        link_pending = 1'b1;
      end
      ir_sawl_pkg::KIND_CLEAR: begin
        rx_ready = 1'b0;
        rx_data_held = '0;
        rx_type_held = '0;
      end
      ir_sawl_pkg::KIND_TICK: begin
        if (it.rxv) begin
          if (it.rxb == ir_sawl_pkg::ACK_BYTE) begin
            link_tx_type = '0;
            link_tx_data = '0;
            link_pending = 1'b0;
          end else if ((it.rxb & ir_sawl_pkg::TYPE_HI_NIBBLE) == ir_sawl_pkg::TYPE_MARK) begin
            rx_type_held = it.rxb[3:0];
          end else if ((it.rxb & ir_sawl_pkg::DATA_TOP_BITS) == ir_sawl_pkg::DATA_MARK &&
                       rx_type_held != 4'd0) begin
            ack = 1'b1;
            rx_data_held = it.rxb[5:0];
            if (rx_type_held == cfg_vote) begin
              ones = 0;
              for (int i = 0; i < 6; i++) ones += rx_data_held[i];
              rx_data_held = (ones > ir_sawl_pkg::VOTE_HALF) ? 6'd1 : 6'd0;
              ack = (ones != ir_sawl_pkg::VOTE_HALF);
            end
            if (ack) begin
              rx_ready = 1'b1;
              emit_byte(1'b1, ir_sawl_pkg::ACK_BYTE);
            end
          end
        end
        if (link_tx_type != 8'h00) begin
          per = (cfg_period == 8'd0) ? 256 : cfg_period;
          if (int'(resend_ticks) % per == 0) begin
            emit_byte(1'b1, link_tx_type);
            resend_ticks = '0;
          end else if (resend_ticks == cfg_offset) begin
            emit_byte(1'b1, link_tx_data);
          end
          resend_ticks = resend_ticks + 8'd1;
        end
      end
      default: ;
    endcase
    if (step_count == 0) emit_byte(1'b0, 8'h00);
    for (int k = 0; k < step_count; k++) begin
      step_results[k].last = (k == step_count - 1);
      step_results[k].pending = link_pending;
      step_results[k].in_ready = rx_ready;
      step_results[k].in_type = rx_ready ? rx_type_held : 4'd0;
      step_results[k].in_data = rx_ready ? rx_data_held : 6'd0;
    end
  endfunction

  function automatic stim_t directed_row(int i);
    ir_sawl_pkg::result_t none;
    none = '0;
    case (i)
      0:  return row(ir_sawl_pkg::KIND_TICK, 1'b0, 8'h00, 4'd0, 6'd0, 1'b1,
                     res(1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 6'd0));
      1:  return row(KIND_UNUSED, 1'b1, 8'hFF, 4'hF, 6'h3F, 1'b1,
                     res(1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 6'd0));
      2:  return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'h7F, 4'd0, 6'd0, 1'b1,
                     res(1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 6'd0));
      3:  return row(ir_sawl_pkg::KIND_CLEAR, 1'b0, 8'h00, 4'd0, 6'd0, 1'b1,
                     res(1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 6'd0));
      4:  return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'hBF, 4'd0, 6'd0, 1'b1,
                     res(1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 6'd0));
      5:  return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'h40, 4'd0, 6'd0, 1'b1,
                     res(1'b1, ir_sawl_pkg::ACK_BYTE, 1'b0, 1'b1, 4'hF, 6'd0));
      6:  return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'h7F, 4'd0, 6'd0, 1'b1,
                     res(1'b1, ir_sawl_pkg::ACK_BYTE, 1'b0, 1'b1, 4'hF, 6'h3F));
      7:  return row(ir_sawl_pkg::KIND_CLEAR, 1'b0, 8'h00, 4'd0, 6'd0, 1'b1,
                     res(1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 6'd0));
      8:  return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'hB2, 4'd0, 6'd0, 1'b1,
                     res(1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 6'd0));
      // tie vote, no ack
      9:  return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'h47, 4'd0, 6'd0, 1'b1,
                     res(1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 6'd0));
      10: return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'h4F, 4'd0, 6'd0, 1'b1,
                     res(1'b1, ir_sawl_pkg::ACK_BYTE, 1'b0, 1'b1, 4'd2, 6'd1));
      11: return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'h41, 4'd0, 6'd0, 1'b1,
                     res(1'b1, ir_sawl_pkg::ACK_BYTE, 1'b0, 1'b1, 4'd2, 6'd0));
      12: return row(ir_sawl_pkg::KIND_SEND, 1'b0, 8'h00, 4'hF, 6'h3F, 1'b1,
                     res(1'b0, 8'h00, 1'b1, 1'b1, 4'd2, 6'd0));
      13: return row(ir_sawl_pkg::KIND_TICK, 1'b0, 8'h00, 4'd0, 6'd0, 1'b1,
                     res(1'b1, 8'hBF, 1'b1, 1'b1, 4'd2, 6'd0));
      14: return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'hB0, 4'd0, 6'd0, 1'b0, none);
      15: return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'h55, 4'd0, 6'd0, 1'b0, none);
      16: return row(ir_sawl_pkg::KIND_SEND, 1'b0, 8'h00, 4'd0, 6'd0, 1'b0, none);
      17: return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'hB3, 4'd0, 6'd0, 1'b0, none);
      18: return row(ir_sawl_pkg::KIND_SEND, 1'b0, 8'h00, 4'd5, 6'h2A, 1'b0, none);
      // ack and type resend on one tick
      19: return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'h60, 4'd0, 6'd0, 1'b0, none);
      20: return row(ir_sawl_pkg::KIND_TICK, 1'b1, ir_sawl_pkg::ACK_BYTE, 4'd0, 6'd0, 1'b0,
                     none);
      21: return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'hFF, 4'd0, 6'd0, 1'b0, none);
      default: return row(ir_sawl_pkg::KIND_TICK, 1'b1, 8'h80, 4'd0, 6'd0, 1'b0, none);
    endcase
  endfunction

  function automatic stim_t random_item(int send_pct, int ack_pct);
    stim_t s;
    int r;
    logic [3:0] nib;
    s = '0;
    s.rxv = ($urandom_range(0, 99) < 55);
    s.rxb = 8'($urandom_range(0, 255));
    s.stype = 4'($urandom_range(0, 15));
    s.sdata = 6'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < send_pct) s.kind = ir_sawl_pkg::KIND_SEND;
    else if (r < send_pct + 4) s.kind = ir_sawl_pkg::KIND_CLEAR;
    else if (r < send_pct + 6) s.kind = KIND_UNUSED;
    else s.kind = ir_sawl_pkg::KIND_TICK;
    r = $urandom_range(0, 99);
    if (r < ack_pct) begin
      s.rxb = ir_sawl_pkg::ACK_BYTE;
    end else if (r < ack_pct + 35) begin
      r = $urandom_range(0, 9);
      nib = (r < 4) ? cfg_vote : (r < 5) ? 4'd0 : 4'($urandom_range(0, 15));
      s.rxb = ir_sawl_pkg::TYPE_MARK | {4'h0, nib};
    end else if (r < ack_pct + 80) begin
      s.rxb = ir_sawl_pkg::DATA_MARK | {2'b00, 6'($urandom_range(0, 63))};
    end
    return s;
  endfunction

  task automatic report(string what, int got, int want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t ns mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    stim_t it;
    ir_sawl_pkg::result_t got;
    ir_sawl_pkg::result_t want;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          ir_sawl_pkg::REG_VOTE_TYPE:     cfg_vote = cfg_data[3:0];
          ir_sawl_pkg::REG_RESEND_PERIOD: cfg_period = cfg_data;
          ir_sawl_pkg::REG_DATA_OFFSET:   cfg_offset = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it = offered.pop_front();
        predict_link_step(it);
        if (it.typed) begin
          awaited_results.push_back(it.want);
        end else begin
          for (int k = 0; k < step_count; k++) awaited_results.push_back(step_results[k]);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.tx_valid = m_axis_tdata[0];
        got.tx_byte = m_axis_tdata[8:1];
        got.last = m_axis_tlast;
        got.pending = m_axis_tdata[9];
        got.in_ready = m_axis_tdata[10];
        got.in_type = m_axis_tdata[14:11];
        got.in_data = m_axis_tdata[20:15];
        results_seen++;
        if (awaited_results.size() == 0) begin
          report("unexpected transaction", int'(got), 0);
        end else begin
          want = awaited_results.pop_front();
          if (got.tx_valid !== want.tx_valid) report("tx_valid", got.tx_valid, want.tx_valid);
          if (got.tx_byte !== want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
          if (got.last !== want.last) report("last", got.last, want.last);
          if (got.pending !== want.pending) report("pending", got.pending, want.pending);
          if (got.in_ready !== want.in_ready) report("in_ready", got.in_ready, want.in_ready);
          if (got.in_type !== want.in_type) report("in_type", got.in_type, want.in_type);
          if (got.in_data !== want.in_data) report("in_data", got.in_data, want.in_data);
        end
      end
    end
  end

  task automatic offer(stim_t it);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, it.sdata, it.stype, it.rxb, it.rxv};
    s_axis_tuser <= it.kind;
    offered.push_back(it);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain(int extra);
    s_axis_tvalid <= 1'b0;
    while (offered.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [ir_sawl_pkg::CFG_INDEX_W-1:0] idx,
                           logic [ir_sawl_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  initial begin : sink
    int hold_cycles;
    bit held_once;
    held_once = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held_once && results_seen >= 300) begin
        held_once = 1'b1;
        m_axis_tready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 150) begin
          @(posedge clk);
          hold_cycles++;
        end
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int vote;
    int per;
    int off;
    int send_pct;
    int ack_pct;
    int count;
    stim_t first;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) offer(directed_row(i));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain(16);
      case (ph)
        0: begin
          vote = 0; per = 2; off = 1; send_pct = 10; ack_pct = 20; count = 120;
        end
        // longest period and offset
        1: begin
          vote = 15; per = 255; off = 254; send_pct = 0; ack_pct = 0; count = 300;
        end
        // zero period wraps at 256 ticks
        2: begin
          vote = 2; per = 0; off = 14; send_pct = 0; ack_pct = 0; count = 300;
        end
        default: begin
          vote = $urandom_range(0, 15);
          per = $urandom_range(2, 40);
          off = $urandom_range(1, per + 4);
          send_pct = 5; ack_pct = 10; count = 120;
        end
      endcase
      write_reg(ir_sawl_pkg::REG_VOTE_TYPE, 8'(vote));
      write_reg(ir_sawl_pkg::REG_RESEND_PERIOD, 8'(per));
      write_reg(ir_sawl_pkg::REG_DATA_OFFSET, 8'(off));
      cfg_we <= 1'b0;
      quiet = (ph == NUM_PHASES - 1);
      first = random_item(100, 0);
      offer(first);
      for (int n = 1; n < count; n++) offer(random_item(send_pct, ack_pct));
    end

    drain(24);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ir_sawl_pkg.sv
rtl/ir_sawl_front.sv
rtl/ir_sawl_rem.sv
rtl/ir_sawl_back.sv
rtl/ir_stop_and_wait_link.sv
sim/testbench.sv
